>>> design/block_map_radix_walker_assert.svh
`ifndef BLOCK_MAP_RADIX_WALKER_ASSERT_SVH
`define BLOCK_MAP_RADIX_WALKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BMRW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BMRW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bmrw_pkg.sv
package bmrw_pkg;

	localparam int DIRECT_SLOTS = 12;
	localparam int ROOT_COUNT   = 15;
	localparam int SLOT_SINGLE  = 12;
	localparam int SLOT_DOUBLE  = 13;
	localparam int SLOT_TRIPLE  = 14;

	localparam logic [3:0] LG_MIN   = 4'd8;
	localparam logic [3:0] LG_MAX   = 4'd10;
	localparam logic [3:0] LG_RESET = 4'd8;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_ENTRY  = 2'd2;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_READ_ERR = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [31:0] root_pointer;
		logic [31:0] logical_block;
		logic [31:0] entry_word;
		logic        read_failed;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] read_block;
		logic [9:0]  read_index;
		logic [31:0] physical_block;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [31:0] data;
	} root_wr_t;

	typedef struct packed {
		logic [31:0] direct;
		logic [31:0] single;
		logic [31:0] dbl;
		logic [31:0] triple;
	} root_view_t;

	typedef struct packed {
		logic [31:0] end_single;
		logic [31:0] end_double;
		logic [31:0] end_triple;
	} bounds_t;

	function automatic logic [3:0] clamp_lg(input logic [3:0] raw);
		logic [3:0] lg;
		lg = raw;
		if (raw < LG_MIN)
			lg = LG_MIN;
		else if (raw > LG_MAX)
			lg = LG_MAX;
		return lg;
	endfunction

	function automatic bounds_t tree_bounds(input logic [3:0] lg);
		logic [32:0] ents;
		logic [32:0] e1;
		logic [32:0] e2;
		logic [32:0] e3;
		bounds_t     b;
		ents = 33'd1 << lg;
		e1   = 33'(DIRECT_SLOTS) + ents;
		e2   = e1 + (ents << lg);
		e3   = e2 + (ents << {lg, 1'b0});
		b.end_single = e1[31:0];
		b.end_double = e2[31:0];
		b.end_triple = e3[31:0];
		return b;
	endfunction

endpackage

>>> design/bmrw_roots.sv
module bmrw_roots
	import bmrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  root_wr_t    wr,
	input  logic [3:0]  rd_idx,
	output root_view_t  view
);

	logic [31:0] roots_q [ROOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_COUNT; i++)
				roots_q[i] <= '0;
		end else if (wr.en && (wr.slot < 4'(ROOT_COUNT))) begin
			roots_q[wr.slot] <= wr.data;
		end
	end

	always_comb begin
		view.direct = (rd_idx < 4'(DIRECT_SLOTS)) ? roots_q[rd_idx] : '0;
		view.single = roots_q[SLOT_SINGLE];
		view.dbl    = roots_q[SLOT_DOUBLE];
		view.triple = roots_q[SLOT_TRIPLE];
	end

endmodule

>>> design/bmrw_walk.sv
module bmrw_walk
	import bmrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [3:0]  lg,
	input  root_view_t  roots,
	output logic [3:0]  root_rd_idx,
	output logic        res_hit,
	output result_t     res
);

	logic [1:0]  levels_q;
	logic [9:0]  second_q;
	logic [9:0]  third_q;

	logic [1:0]  levels_d;
	logic [9:0]  second_d;
	logic [9:0]  third_d;

	bounds_t     bnd;
	logic [31:0] lb;
	logic [31:0] b1;
	logic [31:0] b2;
	logic [31:0] b3;
	logic [9:0]  mask;
	logic [5:0]  lg2;

	logic [31:0] st_root;
	logic [1:0]  st_levels;
	logic [9:0]  st_i1;
	logic [9:0]  st_i2;
	logic [9:0]  st_i3;
	logic        st_go;

	assign lb          = item.logical_block;
	assign root_rd_idx = lb[3:0];
	assign bnd         = tree_bounds(lg);
	assign b1          = lb - 32'(DIRECT_SLOTS);
	assign b2          = lb - bnd.end_single;
	assign b3          = lb - bnd.end_double;
	assign mask        = ~(10'h3FF << lg);
	assign lg2         = {1'b0, lg, 1'b0};

	always_comb begin
		st_go     = 1'b0;
		st_root   = '0;
		st_levels = '0;
		st_i1     = '0;
		st_i2     = '0;
		st_i3     = '0;
		if (lb < bnd.end_single) begin
			st_root   = roots.single;
			st_levels = 2'd1;
			st_i1     = b1[9:0];
		end else if (lb < bnd.end_double) begin
			st_root   = roots.dbl;
			st_levels = 2'd2;
			st_i1     = 10'(b2 >> lg);
			st_i2     = b2[9:0] & mask;
		end else begin
			st_root   = roots.triple;
			st_levels = 2'd3;
			st_i1     = 10'(b3 >> lg2);
			st_i2     = 10'(b3 >> lg) & mask;
			st_i3     = b3[9:0] & mask;
		end
		st_go = (st_root != '0);
	end

	always_comb begin
		levels_d = levels_q;
		second_d = second_q;
		third_d  = third_q;
		res_hit  = 1'b0;
		res      = '0;
		case (item.func)
			FUNC_LOOKUP: begin
				res_hit  = 1'b1;
				levels_d = '0;
				if (lb < 32'(DIRECT_SLOTS)) begin
					res.kind           = KIND_DONE;
					res.physical_block = roots.direct;
					res.status         = STAT_OK;
				end else if (lb >= bnd.end_triple) begin
					res.kind   = KIND_DONE;
					res.status = STAT_RANGE;
				end else if (!st_go) begin
					res.kind   = KIND_DONE;
					res.status = STAT_OK;
				end else begin
					levels_d       = st_levels;
					second_d       = st_i2;
					third_d        = st_i3;
					res.kind       = KIND_REQUEST;
					res.read_block = st_root;
					res.read_index = st_i1;
				end
			end
			FUNC_ENTRY: begin
				if (levels_q != '0) begin
					res_hit  = 1'b1;
					res.kind = KIND_DONE;
					levels_d = '0;
					if (item.read_failed) begin
						res.status = STAT_READ_ERR;
					end else if (levels_q == 2'd1) begin
						res.physical_block = item.entry_word;
					end else if (item.entry_word != '0) begin
						levels_d       = levels_q - 2'd1;
						second_d       = third_q;
						third_d        = '0;
						res.kind       = KIND_REQUEST;
						res.read_block = item.entry_word;
						res.read_index = second_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
			second_q <= '0;
			third_q  <= '0;
		end else if (fire) begin
			levels_q <= levels_d;
			second_q <= second_d;
			third_q  <= third_d;
		end
	end

endmodule

>>> design/block_map_radix_walker.sv
// Logical-to-physical block walker for a 12-direct, single, double and
// triple indirect pointer tree. Load the fifteen root pointers with load
// items, then send lookups; a lookup answers with a finished result or a
// read request for one indirect entry, and each returned entry item answers
// with the next request or the finished result. One item is taken every
// cycle while item_stall is low; each item passes an input register and
// the walk logic, and its result, if any, then leaves from the output
// register. item_stall rises only while the output register holds a
// stalled result and the input register is full. Root pointers and walk
// state clear at reset; entries_log2 resets to 8 and values outside 8..10
// act as the nearest bound. Write cfg only while no walk is in flight.
module block_map_radix_walker
	import bmrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	item_t       item_s1;
	logic        valid_s1;
	result_t     result_q;
	logic        result_valid_q;
	logic [3:0]  entries_log2_q;

	logic        advance;
	logic        fire;
	logic        res_hit;
	result_t     res;
	root_wr_t    root_wr;
	root_view_t  root_view;
	logic [3:0]  root_rd_idx;

	assign advance      = !result_valid_q || !result_stall;
	assign item_stall   = valid_s1 && !advance;
	assign fire         = valid_s1 && advance;
	assign cfg_ready    = 1'b1;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign root_wr.en   = fire && (item_s1.func == FUNC_LOAD);
	assign root_wr.slot = item_s1.slot;
	assign root_wr.data = item_s1.root_pointer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_log2_q <= LG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entries_log2_q <= clamp_lg(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= fire && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_hit)
			result_q <= res;
	end

	bmrw_roots u_roots (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (root_wr),
		.rd_idx (root_rd_idx),
		.view   (root_view)
	);

	bmrw_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.lg          (entries_log2_q),
		.roots       (root_view),
		.root_rd_idx (root_rd_idx),
		.res_hit     (res_hit),
		.res         (res)
	);

endmodule

>>> design/bmrw_checker.sv
`include "block_map_radix_walker_assert.svh"

module bmrw_checker
	import bmrw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result
);

	`BMRW_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result item changed")

	`BMRW_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "input stalled without a stalled result")

	`BMRW_ASSERT_NEXT(a_no_phantom, !(item_valid && !item_stall) ##1 (!(item_valid && !item_stall) && !result_valid), !result_valid, "result item with no item accepted")

endmodule

bind block_map_radix_walker bmrw_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> dv/block_map_radix_walker_test.sv
`timescale 1ns / 1ps

module block_map_radix_walker_test;
	import bmrw_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [3:0] SLOT_NONE   = 4'd15;
	localparam int         HOLD_CYCLES = 300;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [3:0] cfg_data;

	logic [31:0] walk_roots [ROOT_COUNT];
	logic [1:0]  walk_levels;
	logic [9:0]  walk_idx2;
	logic [9:0]  walk_idx3;
	logic [3:0]  map_lg;

	result_t translations_due [$];

	int errors;
	int items_sent;
	int results_seen;
	int settings_written;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_request;
	int hold_left;

	block_map_radix_walker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [3:0] eff_lg();
		if (map_lg < LG_MIN)
			return LG_MIN;
		if (map_lg > LG_MAX)
			return LG_MAX;
		return map_lg;
	endfunction

	function automatic void finish_walk(output result_t r, input logic [31:0] phys,
			input logic [1:0] st);
		r = '0;
		r.kind = KIND_DONE;
		r.physical_block = phys;
		r.status = st;
		walk_levels = 2'd0;
	endfunction

	function automatic void open_walk(output result_t r, input logic [31:0] root,
			input logic [1:0] levels, input logic [9:0] i1, input logic [9:0] i2,
			input logic [9:0] i3);
		if (root == 32'd0) begin
			finish_walk(r, 32'd0, STAT_OK);
		end else begin
			r = '0;
			r.kind = KIND_REQUEST;
			r.read_block = root;
			r.read_index = i1;
			walk_levels = levels;
			walk_idx2 = i2;
			walk_idx3 = i3;
		end
	endfunction

	function automatic bit translate_item(input item_t it, output result_t r);
		logic [3:0]  lg;
		logic [63:0] ents;
		logic [63:0] mask;
		logic [63:0] lb;
		logic [63:0] lo;
		logic [63:0] b;
		r = '0;
		lg = eff_lg();
		ents = 64'd1 << lg;
		mask = ents - 64'd1;
		case (it.func)
			FUNC_LOAD: begin
				if (it.slot < ROOT_COUNT)
					walk_roots[it.slot] = it.root_pointer;
				return 1'b0;
			end
			FUNC_LOOKUP: begin
				lb = 64'(it.logical_block);
				walk_levels = 2'd0;
				lo = 64'(DIRECT_SLOTS);
				if (lb < lo) begin
					finish_walk(r, walk_roots[lb[3:0]], STAT_OK);
					return 1'b1;
				end
				if (lb < lo + ents) begin
					open_walk(r, walk_roots[SLOT_SINGLE], 2'd1, 10'(lb - lo), 10'd0, 10'd0);
					return 1'b1;
				end
				lo += ents;
				if (lb < lo + ents * ents) begin
					b = lb - lo;
					open_walk(r, walk_roots[SLOT_DOUBLE], 2'd2, 10'(b >> lg), 10'(b & mask),
						10'd0);
					return 1'b1;
				end
				lo += ents * ents;
				if (lb < lo + ents * ents * ents) begin
					b = lb - lo;
					open_walk(r, walk_roots[SLOT_TRIPLE], 2'd3, 10'(b >> (2 * lg)),
						10'((b >> lg) & mask), 10'(b & mask));
					return 1'b1;
				end
				finish_walk(r, 32'd0, STAT_RANGE);
				return 1'b1;
			end
			FUNC_ENTRY: begin
				if (walk_levels == 2'd0)
					return 1'b0;
				if (it.read_failed) begin
					finish_walk(r, 32'd0, STAT_READ_ERR);
					return 1'b1;
				end
				walk_levels = walk_levels - 2'd1;
				if (walk_levels == 2'd0) begin
					finish_walk(r, it.entry_word, STAT_OK);
				end else if (it.entry_word == 32'd0) begin
					finish_walk(r, 32'd0, STAT_OK);
				end else begin
					r.kind = KIND_REQUEST;
					r.read_block = it.entry_word;
					r.read_index = walk_idx2;
					walk_idx2 = walk_idx3;
					walk_idx3 = 10'd0;
				end
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// region: 0-1 direct, 2-3 single, 4-5 double, 6-7 triple, 8 past range, else any
	function automatic logic [31:0] pick_block(input int region);
		logic [63:0] ents;
		logic [63:0] lo;
		logic [63:0] span;
		ents = 64'd1 << eff_lg();
		lo = 64'(DIRECT_SLOTS);
		span = ents;
		case (region)
			0, 1: begin
				lo = 64'd0;
				span = 64'(DIRECT_SLOTS);
			end
			2, 3: begin
			end
			4, 5: begin
				lo += ents;
				span = ents * ents;
			end
			6, 7: begin
				lo += ents + ents * ents;
				span = ents * ents * ents;
			end
			8: begin
				lo += ents + ents * ents + ents * ents * ents;
				span = 64'h1_0000_0000 - lo;
			end
			default: begin
				return $urandom;
			end
		endcase
		case ($urandom_range(9))
			0: return 32'(lo);
			1: return 32'(lo + span - 64'd1);
			default: return 32'(lo + ({$urandom, $urandom} % span));
		endcase
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.func = 2'($urandom_range(3));
		it.slot = 4'($urandom_range(15));
		it.root_pointer = $urandom;
		it.logical_block = $urandom;
		it.entry_word = $urandom;
		it.read_failed = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic item_t mk(input logic [1:0] func, input logic [3:0] slot,
			input logic [31:0] ptr, input logic [31:0] lb, input logic [31:0] word,
			input logic failed);
		item_t it;
		it.func = func;
		it.slot = slot;
		it.root_pointer = ptr;
		it.logical_block = lb;
		it.entry_word = word;
		it.read_failed = failed;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		result_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (translate_item(it, r))
			translations_due.push_back(r);
		items_sent++;
	endtask

	task automatic settle();
		if (walk_levels != 2'd0)
			send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		item_valid <= 1'b0;
		while (translations_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_entries_log2(input logic [3:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		map_lg = value;
		settings_written++;
	endtask

	task automatic load_roots();
		item_t it;
		for (int s = 0; s < ROOT_COUNT; s++) begin
			it = noise_item();
			it.func = FUNC_LOAD;
			it.slot = 4'(s);
			if ($urandom_range(9) == 0)
				it.root_pointer = 32'd0;
			send_item(it);
		end
	endtask

	task automatic random_walk();
		item_t it;
		int pick;
		it = noise_item();
		it.func = FUNC_LOOKUP;
		it.logical_block = pick_block($urandom_range(9));
		send_item(it);
		while (walk_levels != 2'd0) begin
			pick = $urandom_range(99);
			if (pick < 3)
				return;
			it = noise_item();
			if (pick < 8) begin
				it.func = FUNC_LOAD;
			end else begin
				it.func = FUNC_ENTRY;
				it.read_failed = ($urandom_range(99) < 5);
				if ($urandom_range(99) < 12)
					it.entry_word = 32'd0;
			end
			send_item(it);
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(29))
				0: load_roots();
				1, 2, 3: send_item(noise_item());
				default: random_walk();
			endcase
		end
	endtask

	task automatic test_directed();
		// lookups below assume 256 pointers per block
		send_item(mk(FUNC_LOAD, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, 4'd11, 32'd1, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, 4'(SLOT_SINGLE), 32'h100, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, 4'(SLOT_DOUBLE), 32'h200, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, 4'(SLOT_TRIPLE), 32'h8000_0000, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, SLOT_NONE, 32'h0000_DEAD, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd11, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd5, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd12, 32'd0, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd65803, 32'd0, 1'b0));
		send_item(mk(FUNC_LOAD, 4'(SLOT_SINGLE), 32'd0, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'h300, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd16843019, 32'd0, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd16843020, 32'd0, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'h1234, 1'b0));
		send_item(mk(FUNC_UNUSED, 4'd3, 32'd7, 32'd12, 32'd9, 1'b1));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd268, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0));
		send_item(mk(FUNC_LOOKUP, 4'd0, 32'd0, 32'd65804, 32'd0, 1'b0));
		send_item(mk(FUNC_ENTRY, 4'd0, 32'd0, 32'd0, 32'h55, 1'b1));
		settle();
	endtask

	task automatic test_config();
		logic [3:0] values [8];
		values = '{LG_MIN, LG_MAX, 4'd0, 4'd15, 4'd9, 4'd7, 4'd11, 4'($urandom_range(15))};
		foreach (values[i]) begin
			settle();
			write_entries_log2(values[i]);
			load_roots();
			run_random(40);
		end
		settle();
	endtask

	task automatic test_idle_modes();
		int send_pct [3];
		int recv_pct [3];
		send_pct = '{33, 85, 0};
		recv_pct = '{85, 33, 0};
		for (int m = 0; m < 3; m++) begin
			settle();
			send_idle_pct = send_pct[m];
			recv_idle_pct = recv_pct[m];
			write_entries_log2(4'($urandom_range(LG_MIN, LG_MAX)));
			load_roots();
			run_random(340);
		end
		settle();
	endtask

	task automatic test_backpressure();
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = HOLD_CYCLES;
		run_random(100);
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (translations_due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none actual %p",
					$time, result);
			end else begin
				want = translations_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("read_block", want.read_block, result.read_block);
				check_field("read_index", 32'(want.read_index), 32'(result.read_index));
				check_field("physical_block", want.physical_block, result.physical_block);
				check_field("status", 32'(want.status), 32'(result.status));
				results_seen++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		settings_written = 0;
		send_idle_pct = 10;
		recv_idle_pct = 10;
		hold_request = 0;
		hold_left = 0;
		foreach (walk_roots[i])
			walk_roots[i] = 32'd0;
		walk_levels = 2'd0;
		walk_idx2 = 10'd0;
		walk_idx3 = 10'd0;
		map_lg = LG_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config();
		test_idle_modes();
		test_backpressure();
		repeat (10) @(posedge clk);
		if (translations_due.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived, expected 0 actual %0d", $time,
				translations_due.size(), translations_due.size());
		end
		$display("Sent %0d items and checked %0d results across %0d register writes,",
			items_sent, results_seen, settings_written);
		$display("three idle mixes and a %0d-cycle output hold.", HOLD_CYCLES);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
